// ===== rtl/rop_pkg.sv =====
// ----------------------------------------------------------------------------
// rop_pkg
// shared types and constants of the raster to oled page packer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rop_pkg;

  // default sizes
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int FRAME_ROWS_DEF = 64;

  // fixed field widths
  localparam int LEVEL_W = 8;
  localparam int BYTE_W  = 8;
  localparam int CFG_W   = 9;
  localparam int PAGE_ROWS = 8;

  // pixel and nibble constants
  localparam logic [LEVEL_W-1:0] ON_THRESHOLD   = 8'h7F;
  localparam logic [BYTE_W-1:0]  HI_NIBBLE_MASK = 8'hF0;
  localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST = 9'd128;
  localparam logic [CFG_W-1:0]   MIN_WIDTH       = 9'd2;

  // configuration register indexes
  localparam logic CFG_PACK_MODE   = 1'b0;
  localparam logic CFG_FRAME_WIDTH = 1'b1;

  typedef enum logic {
    MODE_MONO = 1'b0,
    MODE_GRAY = 1'b1
  } pack_mode_t;

  // control handed from the packer to the column chain
  typedef struct packed {
    logic              shift;
    logic [BYTE_W-1:0] data;
  } rop_chain_ctl_t;

endpackage : rop_pkg

`default_nettype wire

// ===== rtl/rop_cell.sv =====
// ----------------------------------------------------------------------------
// rop_cell
// one column entry of the line store ring
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rop_cell
  import rop_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              shift,
  input  wire logic              sel_inject,
  input  wire logic [BYTE_W-1:0] inject_data,
  input  wire logic [BYTE_W-1:0] prev_data,
  output logic      [BYTE_W-1:0] data
);

  logic [BYTE_W-1:0] data_r;
  logic [BYTE_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (shift) begin
      data_nxt = sel_inject ? inject_data : prev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r <= '0;
    end else begin
      data_r <= data_nxt;
    end
  end

  assign data = data_r;

endmodule : rop_cell

`default_nettype wire

// ===== rtl/rop_col_chain.sv =====
// ----------------------------------------------------------------------------
// rop_col_chain
// row of column cells forming a ring whose length follows the frame width
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rop_col_chain
  import rop_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  localparam int COLW = $clog2(MAX_WIDTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rop_chain_ctl_t    ctl,
  input  wire logic [COLW-1:0]   inject_pos,
  output logic      [BYTE_W-1:0] tail_data
);

  logic [BYTE_W-1:0] cell_q [MAX_WIDTH];

  // new entries enter at inject_pos and move one cell toward the far end on each shift
  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [BYTE_W-1:0] prev;
    if (i == 0) begin : g_head
      assign prev = '0;
    end else begin : g_body
      assign prev = cell_q[i-1];
    end

    rop_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .shift       (ctl.shift),
      .sel_inject  (inject_pos == COLW'(i)),
      .inject_data (ctl.data),
      .prev_data   (prev),
      .data        (cell_q[i])
    );
  end

  assign tail_data = cell_q[MAX_WIDTH-1];

endmodule : rop_col_chain

`default_nettype wire

// ===== rtl/raster_to_oled_page_packer.sv =====
// ----------------------------------------------------------------------------
// raster_to_oled_page_packer
// repacks raster red levels into page-mode oled controller bytes
// ----------------------------------------------------------------------------
// channel | direction | signals                                   | item
// in      | sink      | in_valid in_ready in_red_level            | one pixel
// out     | source    | out_valid out_ready out_packed_byte       | one byte
//         |           | out_frame_end                             |
// cfg     | sink      | cfg_wr_en cfg_index cfg_wdata             | register write
//
// one pixel transfer per cycle; a pixel that yields no byte is always taken
// a byte-producing pixel waits only while the output register is full and
// out_ready is low; the output register is the only stage between the sides
// the line store ring advances once per mono pixel, one column per cycle while pixels are taken
// synchronous active-low reset clears the line store, counters and output valid, not the output payload
// a register write restarts the frame at column 0, row 0
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module raster_to_oled_page_packer
  import rop_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int FRAME_ROWS = FRAME_ROWS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // pixel input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [LEVEL_W-1:0] in_red_level,
  // byte output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [BYTE_W-1:0]  out_packed_byte,
  output logic                    out_frame_end,
  // configuration writes
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_index,
  input  wire logic [CFG_W-1:0]   cfg_wdata
);

  localparam int COLW = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int CW   = (WW > CFG_W) ? WW : CFG_W;
  localparam int ROWW = $clog2(FRAME_ROWS);

  // configuration
  pack_mode_t       mode_r;
  logic [CFG_W-1:0] width_cfg_r;

  // frame position and gray pairing
  logic [COLW-1:0] col_r, col_nxt;
  logic [ROWW-1:0] row_r, row_nxt;
  logic [3:0]      held_r, held_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_end_r, out_end_nxt;

  // datapath
  logic [CW-1:0]     w_eff;
  logic [CW-1:0]     cfg_ext;
  logic [CW-1:0]     col_ext;
  logic [CW-1:0]     col_inc;
  logic [COLW-1:0]   col_eff;
  logic              last_col;
  logic              last_row;
  logic [2:0]        sub;
  logic              will_emit;
  logic              accept;
  logic              pix_on;
  logic [BYTE_W-1:0] store_rd;
  logic [BYTE_W-1:0] entry;
  logic [BYTE_W-1:0] emit_byte;
  logic [COLW-1:0]   inject_pos;
  rop_chain_ctl_t    chain_ctl;

  // width in use saturates to [2, MAX_WIDTH]
  always_comb begin
    cfg_ext = CW'(width_cfg_r);
    if (cfg_ext < CW'(MIN_WIDTH)) begin
      w_eff = CW'(MIN_WIDTH);
    end else if (cfg_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = cfg_ext;
    end
  end

  // ring length equals the width in use
  assign inject_pos = COLW'(CW'(MAX_WIDTH) - w_eff);

  always_comb begin
    col_ext  = CW'(col_r);
    col_eff  = (col_ext >= w_eff) ? '0 : col_r;
    last_col = (CW'(col_eff) == w_eff - CW'(1));
    last_row = (row_r == ROWW'(FRAME_ROWS - 1));
    sub      = row_r[2:0];
    pix_on   = (in_red_level > ON_THRESHOLD);
  end

  // whether the current pixel completes a byte; depends on state only
  always_comb begin
    if (mode_r == MODE_GRAY) begin
      will_emit = col_eff[0] | last_col;
    end else begin
      will_emit = (sub == 3'(PAGE_ROWS - 1)) | last_row;
    end
  end

  assign in_ready = !will_emit || !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // mono: fold the pixel into its column byte, top row of page in bit 0
  always_comb begin
    if (sub == '0) begin
      entry = BYTE_W'(pix_on);
    end else begin
      entry = store_rd | (BYTE_W'(pix_on) << sub);
    end
  end

  always_comb begin
    if (mode_r == MODE_GRAY) begin
      if (col_eff[0]) begin
        emit_byte = {held_r, in_red_level[7:4]};
      end else begin
        // lone last pixel of an odd-width row
        emit_byte = in_red_level & HI_NIBBLE_MASK;
      end
    end else begin
      emit_byte = entry;
    end
  end

  // ring update: finished bytes leave a cleared entry behind
  always_comb begin
    chain_ctl.shift = accept && (mode_r == MODE_MONO);
    chain_ctl.data  = will_emit ? '0 : entry;
  end

  rop_col_chain #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_chain (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (chain_ctl),
    .inject_pos (inject_pos),
    .tail_data  (store_rd)
  );

  // position, held nibble and output register next values
  always_comb begin
    col_nxt       = col_r;
    row_nxt       = row_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    col_inc       = CW'(col_eff) + CW'(1);

    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      // restart of the frame
      col_nxt  = '0;
      row_nxt  = '0;
      held_nxt = '0;
    end else if (accept) begin
      if (col_inc == w_eff) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + ROWW'(1);
      end else begin
        col_nxt = COLW'(col_inc);
      end
      if ((mode_r == MODE_GRAY) && !will_emit) begin
        held_nxt = in_red_level[7:4];
      end
    end

    if (accept && will_emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_end_nxt   = last_row && last_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_MONO;
      width_cfg_r <= FRAME_WIDTH_RST;
      col_r       <= '0;
      row_r       <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_PACK_MODE:   mode_r <= pack_mode_t'(cfg_wdata[0]);
          CFG_FRAME_WIDTH: width_cfg_r <= cfg_wdata;
          default:         mode_r <= mode_r;
        endcase
      end
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_packed_byte = out_byte_r;
  assign out_frame_end   = out_end_r;

  // column counter stays inside the width in use
  a_col_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    CW'(col_r) < w_eff)
    else $error("column position beyond frame width");

  // a byte-producing transfer never overwrites an untaken output byte
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && will_emit) |-> (!out_valid_r || out_ready))
    else $error("output byte overwritten");

  // the frame-end byte wraps the position back to the frame start
  a_frame_wrap : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && will_emit && last_row && last_col) |=> (col_r == '0 && row_r == '0))
    else $error("position did not wrap after frame end");

endmodule : raster_to_oled_page_packer

`default_nettype wire
